FILE: src/drw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drw_pkg
// Shared widths, constants and types for the datagram replay window check.
// ----------------------------------------------------------------------------
package drw_pkg;

    // Field widths
    localparam int TAG_W = 32;
    localparam int SEQ_W = 64;
    localparam int LEN_W = 11;

    // Header layout and tag value ("LRGD" in ASCII)
    localparam int              HEADER_BYTES = 12;
    localparam logic [TAG_W-1:0] TAG_VALUE   = 32'h4C52_4744;

    // Parameter defaults
    localparam int WINDOW_BITS_DEF  = 64;
    localparam int MAX_DATAGRAM_DEF = 1112;

    // Control from the pipeline to the window unit
    typedef struct packed {
        logic advance;      // request in the input register moves on this cycle
        logic well_formed;  // length, tag and sequence passed the header check
    } t_win_ctrl;

endpackage

FILE: src/drw_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drw_window
// Sliding anti-replay window: highest sequence seen plus a bitmap of the
// numbers just below it. Decides freshness and commits the update.
// ----------------------------------------------------------------------------
module drw_window #(
    parameter int WINDOW_BITS = drw_pkg::WINDOW_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  drw_pkg::t_win_ctrl       i_ctrl,
    input  logic [drw_pkg::SEQ_W-1:0] i_seq,
    output logic                     o_fresh
);

    localparam int IDX_W = $clog2(WINDOW_BITS);

    logic [drw_pkg::SEQ_W-1:0] r_highest;
    logic [drw_pkg::SEQ_W-1:0] n_highest;
    logic [WINDOW_BITS-1:0]    r_bitmap;
    logic [WINDOW_BITS-1:0]    n_bitmap;

    logic                      newer;
    logic [drw_pkg::SEQ_W-1:0] dist_up;
    logic [drw_pkg::SEQ_W-1:0] dist_down;
    logic                      far_up;
    logic                      far_down;
    logic [IDX_W-1:0]          idx_up;
    logic [IDX_W-1:0]          idx_down;
    logic                      fresh;

    // Distances either side of the window anchor
    assign newer     = i_seq > r_highest;
    assign dist_up   = i_seq - r_highest;
    assign dist_down = r_highest - i_seq;
    assign far_up    = dist_up   >= drw_pkg::SEQ_W'(WINDOW_BITS);
    assign far_down  = dist_down >= drw_pkg::SEQ_W'(WINDOW_BITS);
    assign idx_up    = dist_up[IDX_W-1:0];
    assign idx_down  = dist_down[IDX_W-1:0];

    // Decide freshness and form the next window
    always_comb begin
        fresh     = 1'b0;
        n_highest = i_seq;
        n_bitmap  = r_bitmap;
        if (newer) begin
            fresh = 1'b1;
            if (far_up) begin
                n_bitmap = WINDOW_BITS'(1);
            end else begin
                n_bitmap = (r_bitmap << idx_up) | WINDOW_BITS'(1);
            end
        end else begin
            n_highest = r_highest;
            if (!far_down) begin
                if (!r_bitmap[idx_down]) begin
                    fresh    = 1'b1;
                    n_bitmap = r_bitmap | (WINDOW_BITS'(1) << idx_down);
                end
            end
        end
    end

    assign o_fresh = fresh;

    // Commit only for an accepted request; rejected ones leave the window alone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest <= '0;
            r_bitmap  <= '0;
        end else if (i_ctrl.advance && i_ctrl.well_formed && fresh) begin
            r_highest <= n_highest;
            r_bitmap  <= n_bitmap;
        end
    end

endmodule

FILE: src/datagram_replay_window_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datagram_replay_window_check
// Header check and sliding-window replay filter for received datagrams.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while the input stall is low, and
// each gives exactly one result: the request is held in the input register,
// where the length, tag and sequence checks and the window compare, subtract
// and shift all settle, and then moves to the result register. The window
// state is updated at the same edge that loads the result, so the next
// request sees it at once.
// A stall on the result side holds the result register and, through it, the
// input register; input stall rises only while both are full and held.
// ----------------------------------------------------------------------------
module datagram_replay_window_check #(
    parameter int WINDOW_BITS  = drw_pkg::WINDOW_BITS_DEF,
    parameter int MAX_DATAGRAM = drw_pkg::MAX_DATAGRAM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [drw_pkg::TAG_W-1:0] i_tag_word,
    input  logic [drw_pkg::SEQ_W-1:0] i_seq_number,
    input  logic [drw_pkg::LEN_W-1:0] i_datagram_length,
    // Result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_accepted,
    output logic [drw_pkg::SEQ_W-1:0] o_seq_out,
    output logic [drw_pkg::LEN_W-1:0] o_payload_length
);

    logic                      r_in_valid;
    logic [drw_pkg::TAG_W-1:0] r_tag;
    logic [drw_pkg::SEQ_W-1:0] r_seq;
    logic [drw_pkg::LEN_W-1:0] r_len;

    logic                      r_out_valid;
    logic                      r_accepted;
    logic [drw_pkg::SEQ_W-1:0] r_seq_out;
    logic [drw_pkg::LEN_W-1:0] r_payload;

    logic                      advance;
    logic                      load_in;
    logic                      header_ok;
    logic                      fresh;
    logic                      accept;
    drw_pkg::t_win_ctrl        win_ctrl;

    // Handshake: move on when the result register is free or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign load_in    = !r_in_valid || advance;

    // Check the header fields
    assign header_ok = (32'(r_len) >= 32'(drw_pkg::HEADER_BYTES))
                    && (32'(r_len) <= 32'(MAX_DATAGRAM))
                    && (r_tag == drw_pkg::TAG_VALUE)
                    && (r_seq != '0);

    assign win_ctrl.advance     = r_in_valid && advance;
    assign win_ctrl.well_formed = header_ok;

    drw_window #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (win_ctrl),
        .i_seq   (r_seq),
        .o_fresh (fresh)
    );

    assign accept = header_ok && fresh;

    // Hold the request in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in && i_in_valid) begin
            r_tag <= i_tag_word;
            r_seq <= i_seq_number;
            r_len <= i_datagram_length;
        end
    end

    // Load the result; zero the fields of a rejected request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_accepted <= accept;
            r_seq_out  <= accept ? r_seq : '0;
            r_payload  <= accept ? (r_len - drw_pkg::LEN_W'(drw_pkg::HEADER_BYTES)) : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_accepted;
    assign o_seq_out        = r_seq_out;
    assign o_payload_length = r_payload;

endmodule

FILE: src/drw_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drw_check
// Port-level checks for the datagram replay window check, bound to the top.
// ----------------------------------------------------------------------------
module drw_check (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic [drw_pkg::TAG_W-1:0] i_tag_word,
    input logic [drw_pkg::SEQ_W-1:0] i_seq_number,
    input logic [drw_pkg::LEN_W-1:0] i_datagram_length,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_accepted,
    input logic [drw_pkg::SEQ_W-1:0] o_seq_out,
    input logic [drw_pkg::LEN_W-1:0] o_payload_length
);

    // A rejected result carries zero fields
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |-> (o_seq_out == '0 && o_payload_length == '0))
        else $error("rejected result with nonzero fields");

    // An accepted result never carries sequence zero
    a_accept_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (o_seq_out != '0))
        else $error("accepted result with sequence zero");

    // An empty result register never stalls the request side
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("request stalled while result register empty");

    // A stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=>
            (i_in_valid && $stable(i_tag_word) && $stable(i_seq_number)
             && $stable(i_datagram_length)))
        else $error("stalled request changed");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_accepted) && $stable(o_seq_out)
             && $stable(o_payload_length)))
        else $error("stalled result changed");

endmodule

bind datagram_replay_window_check drw_check u_drw_check (.*);
